@@ rtl/fsw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsw_pkg
// Shared types and codes for the feedback step walker: item kinds, walk modes,
// step directions, result actions, register indexes and the config bundle.
// ----------------------------------------------------------------------------
package fsw_pkg;

  // Item kinds carried in in_tuser
  localparam logic [1:0] KIND_POLL  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  // Walk modes
  localparam logic [1:0] MODE_SEEK  = 2'd0;
  localparam logic [1:0] MODE_FLOOR = 2'd1;
  localparam logic [1:0] MODE_COUNT = 2'd2;

  // Direction of the last step sent
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // Result actions
  localparam logic [2:0] ACT_WAIT      = 3'd0;
  localparam logic [2:0] ACT_UP        = 3'd1;
  localparam logic [2:0] ACT_DOWN      = 3'd2;
  localparam logic [2:0] ACT_DONE      = 3'd3;
  localparam logic [2:0] ACT_STUCK     = 3'd4;
  localparam logic [2:0] ACT_WRAPPED   = 3'd5;
  localparam logic [2:0] ACT_EXHAUSTED = 3'd6;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_DEADLINE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SETTLE    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_STEPS = 2'd2;

  // Register reset values
  localparam logic [31:0] DEADLINE_RST  = 32'd60000;
  localparam logic [31:0] SETTLE_RST    = 32'd2000;
  localparam logic [15:0] MAX_STEPS_RST = 16'd32;

  // Step counter width follows the max_steps register
  localparam int STEP_W = 16;

  // Result word: action in the low bits, busy flag above, padded to a byte
  localparam int OUT_TDATA_W = 8;

  typedef struct packed {
    logic [31:0]       deadline_ms;
    logic [31:0]       settle_ms;
    logic [STEP_W-1:0] max_steps;
  } fsw_cfg_t;

  typedef struct packed {
    logic       busy_res;
    logic [2:0] action;
  } fsw_res_t;

endpackage

@@ rtl/fsw_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsw_cfg
// Configuration register bank: deadline, settle time and step limit, written
// through a plain index/data write port.
// ----------------------------------------------------------------------------
module fsw_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fsw_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [fsw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output fsw_pkg::fsw_cfg_t              cfg
);
  import fsw_pkg::*;

  fsw_cfg_t cfg_r;

  // Register writes; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadline_ms <= DEADLINE_RST;
      cfg_r.settle_ms   <= SETTLE_RST;
      cfg_r.max_steps   <= MAX_STEPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEADLINE:  cfg_r.deadline_ms <= cfg_wdata;
        REG_SETTLE:    cfg_r.settle_ms   <= cfg_wdata;
        REG_MAX_STEPS: cfg_r.max_steps   <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/fsw_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsw_core
// Walk state and the per-word decision logic: arms, disarms and judges each
// poll against deadline, settle time, movement, direction and step limit.
// ----------------------------------------------------------------------------
module fsw_core #(
  parameter int READING_WIDTH = 16,
  parameter int TIME_WIDTH    = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fire,
  input  logic [1:0]                      kind,
  input  logic [TIME_WIDTH-1:0]           now_ms,
  input  logic signed [READING_WIDTH-1:0] reading,
  input  logic                            fresh,
  input  logic [1:0]                      start_mode,
  input  logic signed [READING_WIDTH-1:0] start_target,
  input  logic                            start_up,
  input  fsw_pkg::fsw_cfg_t               cfg,
  output fsw_pkg::fsw_res_t               res
);
  import fsw_pkg::*;

  // Walk state
  logic                            walking_r,   walking_nxt;
  logic [1:0]                      mode_r,      mode_nxt;
  logic signed [READING_WIDTH-1:0] goal_r,      goal_nxt;
  logic                            count_up_r,  count_up_nxt;
  logic [1:0]                      last_dir_r,  last_dir_nxt;
  logic signed [READING_WIDTH-1:0] last_rd_r,   last_rd_nxt;
  logic [TIME_WIDTH-1:0]           start_t_r,   start_t_nxt;
  logic [TIME_WIDTH-1:0]           step_t_r,    step_t_nxt;
  logic [STEP_W-1:0]               sent_r,      sent_nxt;

  logic [TIME_WIDTH-1:0]           el_start;
  logic [TIME_WIDTH-1:0]           el_step;
  logic                            sent_nz;
  logic                            wrong_way;
  logic signed [READING_WIDTH-1:0] goal_eff;
  logic                            goal_le0;
  logic [2:0]                      act;

  // Wrapping elapsed times and movement checks
  assign el_start  = now_ms - start_t_r;
  assign el_step   = now_ms - step_t_r;
  assign sent_nz   = (sent_r != '0);
  assign wrong_way = ((last_dir_r == DIR_UP)   && (reading < last_rd_r)) ||
                     ((last_dir_r == DIR_DOWN) && (reading > last_rd_r));

  // In count mode a judged step uses up one from the goal
  assign goal_eff = (sent_nz && (mode_r == MODE_COUNT)) ? goal_r - 1'b1 : goal_r;
  assign goal_le0 = goal_eff[READING_WIDTH-1] || (goal_eff == '0);

  // Next state and action
  always_comb begin
    walking_nxt  = walking_r;
    mode_nxt     = mode_r;
    goal_nxt     = goal_r;
    count_up_nxt = count_up_r;
    last_dir_nxt = last_dir_r;
    last_rd_nxt  = last_rd_r;
    start_t_nxt  = start_t_r;
    step_t_nxt   = step_t_r;
    sent_nxt     = sent_r;
    act          = ACT_WAIT;
    unique case (kind)
      KIND_POLL: begin
        if (walking_r) begin
          priority if (32'(el_start) >= cfg.deadline_ms) begin
            walking_nxt = 1'b0;
            act         = ACT_STUCK;
          end else if (!fresh) begin
            act = ACT_WAIT;
          end else if (sent_nz && (32'(el_step) < cfg.settle_ms)) begin
            act = ACT_WAIT;
          end else if (sent_nz && (reading == last_rd_r)) begin
            walking_nxt = 1'b0;
            act         = (mode_r == MODE_FLOOR) ? ACT_DONE : ACT_STUCK;
          end else if (sent_nz && wrong_way) begin
            walking_nxt = 1'b0;
            act         = ACT_WRAPPED;
          end else begin
            goal_nxt = goal_eff;
            priority if ((mode_r == MODE_SEEK) && (reading == goal_eff)) begin
              walking_nxt = 1'b0;
              act         = ACT_DONE;
            end else if ((mode_r == MODE_COUNT) && goal_le0) begin
              walking_nxt = 1'b0;
              act         = ACT_DONE;
            end else if (sent_r >= cfg.max_steps) begin
              walking_nxt = 1'b0;
              act         = ACT_EXHAUSTED;
            end else begin
              // Send one step
              if (mode_r == MODE_SEEK) begin
                act = (goal_eff > reading) ? ACT_UP : ACT_DOWN;
              end else if (mode_r == MODE_FLOOR) begin
                act = ACT_DOWN;
              end else begin
                act = count_up_r ? ACT_UP : ACT_DOWN;
              end
              last_dir_nxt = (act == ACT_UP) ? DIR_UP : DIR_DOWN;
              last_rd_nxt  = reading;
              step_t_nxt   = now_ms;
              sent_nxt     = sent_r + 1'b1;
            end
          end
        end
      end
      KIND_START: begin
        walking_nxt  = 1'b1;
        mode_nxt     = start_mode;
        goal_nxt     = start_target;
        count_up_nxt = start_up;
        last_dir_nxt = DIR_NONE;
        last_rd_nxt  = '0;
        start_t_nxt  = now_ms;
        step_t_nxt   = '0;
        sent_nxt     = '0;
      end
      KIND_STOP: begin
        walking_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  // State update, once per word leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walking_r  <= 1'b0;
      mode_r     <= MODE_SEEK;
      goal_r     <= '0;
      count_up_r <= 1'b0;
      last_dir_r <= DIR_NONE;
      last_rd_r  <= '0;
      start_t_r  <= '0;
      step_t_r   <= '0;
      sent_r     <= '0;
    end else if (fire) begin
      walking_r  <= walking_nxt;
      mode_r     <= mode_nxt;
      goal_r     <= goal_nxt;
      count_up_r <= count_up_nxt;
      last_dir_r <= last_dir_nxt;
      last_rd_r  <= last_rd_nxt;
      start_t_r  <= start_t_nxt;
      step_t_r   <= step_t_nxt;
      sent_r     <= sent_nxt;
    end
  end

  assign res.action   = act;
  assign res.busy_res = walking_nxt;

endmodule

@@ rtl/feedback_step_walker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_step_walker
// Steps a remote setting up or down and judges each step by a fed-back reading.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one word per item; in_tuser selects poll, start walk or stop walk.
//   out_*  : exactly one result word per input word, in order: action and the
//            busy flag (walk still armed after this word).
//   cfg_*  : write deadline_ms (0), settle_ms (1), max_steps (2) while idle.
// Each word passes one input register, the decision logic, then the result
// register. Throughput is one word per cycle while out_tready does not stall
// the result register; the walk state updates in the same cycle the
// decision is captured, so the next word already sees it.
// Reset (rst_n low at a clock edge) disarms the walk, clears the valid flags
// of both registers and loads the register defaults 60000, 2000 and 32.
// When out_tready is low a held result stalls the decision stage; the input
// register still takes one more word while it is empty.
// ----------------------------------------------------------------------------
module feedback_step_walker #(
  parameter int READING_WIDTH = 16,
  parameter int TIME_WIDTH    = 32,
  localparam int IN_W        = TIME_WIDTH + 2 * READING_WIDTH + 4,
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // now_ms, reading, fresh, start_mode, start_target, start_up (low bit up)
  input  logic [IN_TDATA_W-1:0]            in_tdata,
  // kind
  input  logic [1:0]                       in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // action, busy_res (low bit up)
  output logic [fsw_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [fsw_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [fsw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import fsw_pkg::*;

  // Field offsets inside in_tdata
  localparam int OFS_RD    = TIME_WIDTH;
  localparam int OFS_FRESH = OFS_RD + READING_WIDTH;
  localparam int OFS_MODE  = OFS_FRESH + 1;
  localparam int OFS_TGT   = OFS_MODE + 2;
  localparam int OFS_UP    = OFS_TGT + READING_WIDTH;

  logic            in_v_r;
  logic [IN_W-1:0] in_data_r;
  logic [1:0]      in_kind_r;
  logic            out_v_r;
  fsw_res_t        out_res_r;
  fsw_res_t        core_res;
  fsw_cfg_t        cfg;
  logic            adv;
  logic            fire;

  // Handshake: decision stage moves when the result register can take a word
  assign adv       = !out_v_r || out_tready;
  assign fire      = in_v_r && adv;
  assign in_tready = !in_v_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata[IN_W-1:0];
      in_kind_r <= in_tuser;
    end
  end

  fsw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fsw_core #(
    .READING_WIDTH (READING_WIDTH),
    .TIME_WIDTH    (TIME_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .kind         (in_kind_r),
    .now_ms       (in_data_r[TIME_WIDTH-1:0]),
    .reading      (in_data_r[OFS_RD +: READING_WIDTH]),
    .fresh        (in_data_r[OFS_FRESH]),
    .start_mode   (in_data_r[OFS_MODE +: 2]),
    .start_target (in_data_r[OFS_TGT +: READING_WIDTH]),
    .start_up     (in_data_r[OFS_UP]),
    .cfg          (cfg),
    .res          (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_TDATA_W - 4){1'b0}}, out_res_r};

endmodule
